@@ rtl/core/sdf_pkg.sv @@
// Package for the stream duplicate filter: table size, payload and probe types.
`default_nettype none

package sdf_pkg;

  // Number of distinct values one list can record
  localparam int unsigned TableDepth = 64;
  // Width of the fill count, which also holds the depth itself
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  // One input transfer
  typedef struct packed {
    logic signed [31:0] item_value;
    logic               last_item;
  } sdf_in_t;

  // One result transfer
  typedef struct packed {
    logic signed [31:0] value_out;
    logic               keep;
    logic               last_out;
    logic               overflow;
  } sdf_out_t;

  // Token that walks the cell chain
  typedef struct packed {
    logic               valid;
    logic signed [31:0] value;
    logic               last;
    logic               hit;     // value matched a recorded entry
    logic               placed;  // value was recorded on the way
  } sdf_probe_t;

endpackage

`default_nettype wire

@@ rtl/core/sdf_cell.sv @@
// One table cell: holds one recorded value and passes the probe token on.
`default_nettype none

module sdf_cell (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire [sdf_pkg::CntW-1:0] cell_idx_i,
  input  wire [sdf_pkg::CntW-1:0] count_i,
  input  sdf_pkg::sdf_probe_t    probe_i,
  output sdf_pkg::sdf_probe_t    probe_o
);
  import sdf_pkg::*;

  logic signed [31:0] entry_q;
  sdf_probe_t         probe_q;
  sdf_probe_t         probe_d;
  logic               match;
  logic               write_en;

  // Compare against the stored entry; the first free cell takes a miss
  always_comb begin
    match    = probe_i.valid && (cell_idx_i < count_i) && (entry_q == probe_i.value);
    write_en = probe_i.valid && !probe_i.hit && (cell_idx_i == count_i);
    probe_d        = probe_i;
    probe_d.hit    = probe_i.hit | match;
    probe_d.placed = probe_i.placed | write_en;
  end

  // Entry storage, valid only below the fill count
  always_ff @(posedge clk_i) begin
    if (write_en) begin
      entry_q <= probe_i.value;
    end
  end

  // Token register toward the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  assign probe_o = probe_q;

endmodule

`default_nettype wire

@@ rtl/core/stream_duplicate_filter.sv @@
// Top level: input register, cell chain, fill count and sticky overflow flag.
`default_nettype none

// A start transfer passes the input register and then one register per cell before
// the result strobe rises and the result is taken.
// busy falls at the edge that takes the result, and no new start is taken while busy
// is high, so only one item is in the chain at a time.
// Each result is shown for one cycle and the receiver cannot stall it.
// Reset clears the fill count, overflow flag and token; entries need no reset.
module stream_duplicate_filter (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  input  sdf_pkg::sdf_in_t     in_i,
  output logic                 busy,
  output logic                 result_valid_o,
  output sdf_pkg::sdf_out_t    result_o
);
  import sdf_pkg::*;

  sdf_probe_t            chain [TableDepth+1];
  sdf_probe_t            head_q;
  sdf_probe_t            head_d;
  sdf_probe_t            tail;
  logic                  busy_q;
  logic                  busy_d;
  logic [CntW-1:0]       count_q;
  logic [CntW-1:0]       count_d;
  logic                  ovf_q;
  logic                  ovf_d;
  logic                  accept;
  logic                  lost;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  // Load the token at the head of the chain
  always_comb begin
    head_d        = '0;
    head_d.valid  = accept;
    head_d.value  = in_i.item_value;
    head_d.last   = in_i.last_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else begin
      head_q <= head_d;
    end
  end

  assign chain[0] = head_q;

  // Row of cells, one per table entry
  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    sdf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (CntW'(i)),
      .count_i    (count_q),
      .probe_i    (chain[i]),
      .probe_o    (chain[i+1])
    );
  end

  assign tail = chain[TableDepth];
  // New distinct value with the table full
  assign lost = !tail.hit && !tail.placed;

  // Result and end-of-item bookkeeping
  always_comb begin
    result_valid_o     = tail.valid;
    result_o.value_out = tail.value;
    result_o.keep      = !tail.hit;
    result_o.last_out  = tail.last;
    result_o.overflow  = ovf_q | lost;

    busy_d  = busy_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (tail.valid) begin
      busy_d = 1'b0;
      if (tail.last) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end else begin
        count_d = count_q + CntW'(tail.placed);
        ovf_d   = ovf_q | lost;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/tb_stream_duplicate_filter.sv @@
// Testbench for stream_duplicate_filter: list stimulus, first-occurrence predictor, result check.
`timescale 1ns / 100ps

module tb_stream_duplicate_filter;
  import sdf_pkg::*;

  localparam int unsigned ListItems = 2000;
  localparam int unsigned StallLimit = 1000;  // cycles with no transfer on either side
  localparam int unsigned DrainCycles = TableDepth + 5;

  // Predictor of the per-list table plus queue of expected verdicts
  class dedup_scoreboard;
    logic [31:0] seen_tbl[TableDepth];
    int unsigned seen_fill;
    bit          ovf_sticky;
    sdf_out_t    expected_verdicts[$];
    int unsigned errors;

    function new();
      seen_fill = 0;
      ovf_sticky = 1'b0;
      errors = 0;
    endfunction

    // Accepted input: decide keep/drop and update the table
    function void note_input(sdf_in_t it);
      sdf_out_t exp;
      bit       hit;
      hit = 1'b0;
      for (int unsigned i = 0; i < seen_fill; i++) begin
        if (seen_tbl[i] == it.item_value) hit = 1'b1;
      end
      if (!hit) begin
        if (seen_fill < TableDepth) begin
          seen_tbl[seen_fill] = it.item_value;
          seen_fill++;
        end else begin
          ovf_sticky = 1'b1;
        end
      end
      exp.value_out = it.item_value;
      exp.keep      = !hit;
      exp.last_out  = it.last_item;
      exp.overflow  = ovf_sticky;
      expected_verdicts = {expected_verdicts, exp};
      // list ends: table, count and flag clear
      if (it.last_item) begin
        seen_fill = 0;
        ovf_sticky = 1'b0;
      end
    endfunction

    // Strobed result: compare with the oldest expectation
    function void check_result(sdf_out_t got);
      sdf_out_t exp;
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result: value_out %0d", got.value_out);
        errors++;
        return;
      end
      exp = expected_verdicts.pop_front();
      if (got.value_out !== exp.value_out) begin
        $error("value_out: expected %0d, got %0d", exp.value_out, got.value_out);
        errors++;
      end
      if (got.keep !== exp.keep) begin
        $error("keep: expected %0b, got %0b", exp.keep, got.keep);
        errors++;
      end
      if (got.last_out !== exp.last_out) begin
        $error("last_out: expected %0b, got %0b", exp.last_out, got.last_out);
        errors++;
      end
      if (got.overflow !== exp.overflow) begin
        $error("overflow: expected %0b, got %0b", exp.overflow, got.overflow);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  sdf_in_t  in_bus = '0;
  logic     busy;
  logic     result_valid_o;
  sdf_out_t result_bus;

  dedup_scoreboard sb = new();

  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  bit          no_gaps = 1'b0;
  int unsigned idle_cycles = 0;

  stream_duplicate_filter u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .in_i           (in_bus),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_bus)
  );

  always #10 clk_i = ~clk_i;

  // Result monitor: every strobe is a transfer
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_result(result_bus);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Random words, with the extremes and small values mixed in
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // One transfer; called right after a rising edge, returns after acceptance
  task automatic drive_item(logic [31:0] v, logic l);
    sdf_in_t it;
    if (burst_left == 0) begin
      if (!no_gaps) begin
        start <= 1'b0;
        // long gaps land on every phase of the busy window
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 80)) @(posedge clk_i);
        else repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    it.item_value = v;
    it.last_item  = l;
    start  <= 1'b1;
    in_bus <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_input(it);
    burst_left--;
    items_sent++;
  endtask

  // Whole list, last mark on the final element
  task automatic send_list(logic [31:0] vals[$]);
    for (int i = 0; i < vals.size(); i++) drive_item(vals[i], i == vals.size() - 1);
  endtask

  // Hold off until every outstanding result has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Short list drawn from a small pool, so repeats are common
  task automatic send_short_list();
    logic [31:0] pool[$];
    logic [31:0] vals[$];
    int unsigned len;
    int unsigned psize;
    len   = $urandom_range(1, 16);
    psize = $urandom_range(1, len);
    repeat (psize) pool = {pool, pick_value()};
    repeat (len) vals = {vals, pool[$urandom_range(0, psize - 1)]};
    send_list(vals);
  endtask

  // Long list with more distinct values than the table holds
  task automatic send_overflow_list();
    logic [31:0] pool[$];
    logic [31:0] vals[$];
    logic [31:0] cand;
    int unsigned n;
    int unsigned idx;
    int unsigned extra;
    bit          dup;
    n = $urandom_range(TableDepth + 1, TableDepth + 16);
    while (pool.size() < n) begin
      cand = pick_value();
      dup = 1'b0;
      foreach (pool[k]) if (pool[k] == cand) dup = 1'b1;
      if (!dup) pool = {pool, cand};
    end
    // new values in order, interleaved with repeats of earlier ones
    idx = 0;
    while (idx < n) begin
      if (idx == 0 || $urandom_range(0, 3) != 0) begin
        vals = {vals, pool[idx]};
        idx++;
      end else begin
        vals = {vals, pool[$urandom_range(0, idx - 1)]};
      end
    end
    // tail of repeats drawn from the whole pool, ending on an unrecorded value
    extra = $urandom_range(2, 8);
    repeat (extra) vals = {vals, pool[$urandom_range(0, n - 1)]};
    vals = {vals, pool[n - 1]};
    send_list(vals);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single-element lists at the extremes
    send_list('{32'h8000_0000});
    send_list('{32'h7fff_ffff});
    // repeats of the extremes, zero and minus one
    send_list('{32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff,
                32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
    // back-to-back repeats, last element is a duplicate
    send_list('{32'd5, 32'd5, 32'd5});
    // table clears between lists: same value kept twice
    send_list('{32'd42});
    send_list('{32'd42, 32'd42});
    drain();

    // Random lists; first one forces the table-full case
    send_overflow_list();
    while (items_sent < ListItems) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 11) == 0) send_overflow_list();
      else send_short_list();
      if ($urandom_range(0, 39) == 0) drain();
    end

    // Wait out the results still in flight
    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
